[src/kbce_pkg.sv]
package kbce_pkg;

  localparam int MAX_KEYS = 16;
  localparam int IDX_W    = $clog2(MAX_KEYS);
  localparam int CNT_W    = $clog2(MAX_KEYS + 1);

  localparam int TIME_W = 17;
  localparam int VAL_W  = 16;

  localparam int S_DATA_W = 72;
  localparam int M_DATA_W = 24;

  localparam logic [TIME_W-1:0] T_ONE     = 17'h10000;
  localparam logic [TIME_W:0]   SHORT_LEN = 18'd7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_EVAL   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  typedef struct packed {
    logic        [TIME_W-1:0] t;
    logic signed [VAL_W-1:0]  v;
    logic signed [VAL_W-1:0]  ho;
    logic signed [VAL_W-1:0]  hi;
  } key_t;

endpackage

[src/keyframe_bezier_curve_eval_core.sv]
// Keyframe curve evaluator with a sorted table of up to MAX_KEYS keyframes.
// Input stream: tuser carries the command (insert, remove, evaluate), tdata
// carries time, value, out handle, in handle and remove index. Output stream:
// one word per input word, tdata holds the curve value and the key count,
// tuser holds the status.
// One word is worked on at a time; s_axis_tready is high only while idle.
// Remove and unused commands go straight to the final state. Insert scans
// the table one key per cycle, or goes straight to the final state when the
// table is full. Evaluate scans for the segment one key per cycle, loads both
// keys, runs a restoring divider for the local t and then 14 steps on one
// shared 24x24 multiplier with a 64-bit accumulator; a short segment skips
// the divider and multiplier.
// The result sits in an output register; a new word is accepted while it
// waits. If the receiver stalls, the next result holds in its final state
// until the output register frees up.
// Reset restores the two keys (0,0) and (T_ONE,4096) with zero handles,
// clears the output valid and returns to idle.
module keyframe_bezier_curve_eval_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // time_in[16:0], value_in[32:17], out_handle_in[48:33], in_handle_in[64:49],
  // index[68:65], zero fill
  input  logic [kbce_pkg::S_DATA_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // curve_value[15:0], point_count[20:16], zero fill
  output logic [kbce_pkg::M_DATA_W-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]                    m_axis_tuser
);
  import kbce_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_INS  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_LD0  = 4'd3;
  localparam logic [3:0] S_PREP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_SAT  = 4'd6;
  localparam logic [3:0] S_MAC  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  localparam logic signed [63:0] HALF32 = 64'sd2147483648;
  localparam logic signed [63:0] HALF16 = 64'sd32768;

  logic [3:0]        state_q;
  key_t              key_q [MAX_KEYS];
  logic [CNT_W-1:0]  cnt_q;
  logic [IDX_W-1:0]  i_q;
  logic [TIME_W-1:0] t_q;
  logic [TIME_W-1:0] prev_t_q;
  key_t              new_q;
  key_t              k0_q, k1_q;
  logic              neg_q;
  logic [TIME_W-1:0] len_q;
  logic [TIME_W-1:0] rem_q;
  logic [32:0]       dvd_q;
  logic [5:0]        div_cnt_q;
  logic signed [17:0] u_q;
  logic signed [18:0] m_q;
  logic signed [35:0] u2_q;
  logic signed [36:0] m2_q;
  logic signed [23:0] w0_q, w1_q, w2_q, w3_q;
  logic signed [63:0] acc_q;
  logic [3:0]        step_q;
  logic signed [15:0] res_val_q;
  logic [1:0]        res_st_q;
  logic              m_valid_q;
  logic signed [15:0] m_val_q;
  logic [1:0]        m_st_q;
  logic [4:0]        m_cnt_q;

  // input word fields
  logic [TIME_W-1:0]  in_time;
  logic signed [15:0] in_val, in_ho, in_hi;
  logic [3:0]         in_idx;
  logic               accept;

  assign in_time = s_axis_tdata[16:0];
  assign in_val  = s_axis_tdata[32:17];
  assign in_ho   = s_axis_tdata[48:33];
  assign in_hi   = s_axis_tdata[64:49];
  assign in_idx  = s_axis_tdata[68:65];
  assign s_axis_tready = (state_q == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;

  // load the output register once it is empty or being drained
  logic out_load;
  assign out_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready);

  // shared table read port
  key_t rd_key;
  assign rd_key = key_q[i_q];

  logic ins_more;
  assign ins_more = ({1'b0, i_q} < (IDX_W+1)'(cnt_q)) && (rd_key.t < new_q.t);

  logic scan_hit, scan_last;
  assign scan_hit  = (t_q >= prev_t_q) && (t_q <= rd_key.t);
  assign scan_last = ((IDX_W+1)'(i_q) + (IDX_W+1)'(1)) == (IDX_W+1)'(cnt_q);

  // segment setup
  logic               is_short;
  logic signed [18:0] d_s;
  logic [TIME_W-1:0]  d_mag;
  assign is_short = {1'b0, k1_q.t} < ({1'b0, k0_q.t} + SHORT_LEN);
  assign d_s      = $signed({2'b00, t_q}) - $signed({2'b00, k0_q.t});
  assign d_mag    = d_s[18] ? TIME_W'(-d_s) : d_s[TIME_W-1:0];

  // divider step
  logic [TIME_W:0] r_try;
  logic            q_bit;
  assign r_try = {rem_q, dvd_q[32]};
  assign q_bit = r_try >= {1'b0, len_q};

  // saturate the quotient
  logic signed [17:0] u_sat;
  always_comb begin
    if (neg_q) begin
      u_sat = (dvd_q > 33'd131072) ? -18'sd131072 : -$signed(dvd_q[17:0]);
    end else begin
      u_sat = (dvd_q > 33'd131071) ? 18'sd131071 : $signed(dvd_q[17:0]);
    end
  end

  // shared multiply-accumulate unit
  logic signed [23:0] mul_a, mul_b;
  logic signed [47:0] prod;
  logic signed [63:0] base, sum;
  logic               sh18;
  logic signed [23:0] u3, m3, c0, c1, c2, c3;
  logic signed [23:0] u2_lo, u2_hi, m2_lo, m2_hi;

  assign u3 = 24'(u_q) + (24'(u_q) <<< 1);
  assign m3 = 24'(m_q) + (24'(m_q) <<< 1);
  assign c0 = 24'(k0_q.v);
  assign c1 = 24'(k0_q.v) + 24'(k0_q.ho);
  assign c2 = 24'(k1_q.v) + 24'(k1_q.hi);
  assign c3 = 24'(k1_q.v);
  assign u2_lo = $signed({6'd0, u2_q[17:0]});
  assign u2_hi = 24'(u2_q >>> 18);
  assign m2_lo = $signed({6'd0, m2_q[17:0]});
  assign m2_hi = 24'(m2_q >>> 18);

  always_comb begin
    mul_a = 24'(u_q);
    mul_b = 24'(u_q);
    base  = acc_q;
    sh18  = 1'b0;
    case (step_q)
      4'd0:  begin mul_a = 24'(u_q); mul_b = 24'(u_q); end
      4'd1:  begin mul_a = 24'(m_q); mul_b = 24'(m_q); end
      4'd2:  begin mul_a = u2_lo; mul_b = 24'(u_q); base = HALF32; end
      4'd3:  begin mul_a = u2_hi; mul_b = 24'(u_q); sh18 = 1'b1; end
      4'd4:  begin mul_a = m2_lo; mul_b = 24'(m_q); base = HALF32; end
      4'd5:  begin mul_a = m2_hi; mul_b = 24'(m_q); sh18 = 1'b1; end
      4'd6:  begin mul_a = m2_lo; mul_b = u3; base = HALF32; end
      4'd7:  begin mul_a = m2_hi; mul_b = u3; sh18 = 1'b1; end
      4'd8:  begin mul_a = u2_lo; mul_b = m3; base = HALF32; end
      4'd9:  begin mul_a = u2_hi; mul_b = m3; sh18 = 1'b1; end
      4'd10: begin mul_a = w0_q; mul_b = c0; base = HALF16; end
      4'd11: begin mul_a = w1_q; mul_b = c1; end
      4'd12: begin mul_a = w2_q; mul_b = c2; end
      default: begin mul_a = w3_q; mul_b = c3; end
    endcase
  end

  assign prod = mul_a * mul_b;
  assign sum  = base + (sh18 ? (64'(prod) <<< 18) : 64'(prod));

  logic signed [63:0] r_fin;
  logic signed [15:0] r_sat;
  assign r_fin = sum >>> 16;
  always_comb begin
    if (r_fin > 64'sd32767) begin
      r_sat = 16'sh7fff;
    end else if (r_fin < -64'sd32768) begin
      r_sat = -16'sh8000;
    end else begin
      r_sat = r_fin[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= CNT_W'(2);
      m_valid_q <= 1'b0;
      for (int j = 0; j < MAX_KEYS; j++) begin
        if (j == 1) begin
          key_q[j] <= '{t: T_ONE, v: 16'sd4096, ho: '0, hi: '0};
        end else begin
          key_q[j] <= '0;
        end
      end
    end else begin
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            res_val_q <= '0;
            case (s_axis_tuser)
              CMD_INSERT: begin
                if (cnt_q >= CNT_W'(MAX_KEYS)) begin
                  res_st_q <= ST_FULL;
                  state_q  <= S_DONE;
                end else begin
                  new_q    <= '{t: in_time, v: in_val, ho: in_ho, hi: in_hi};
                  i_q      <= '0;
                  res_st_q <= ST_OK;
                  state_q  <= S_INS;
                end
              end
              CMD_REMOVE: begin
                state_q <= S_DONE;
                if ((int'(in_idx) < int'(cnt_q)) && (cnt_q > CNT_W'(2))) begin
                  for (int j = 0; j < MAX_KEYS - 1; j++) begin
                    if ((j >= int'(in_idx)) && (j + 1 < int'(cnt_q))) begin
                      key_q[j] <= key_q[j+1];
                    end
                  end
                  cnt_q    <= cnt_q - CNT_W'(1);
                  res_st_q <= ST_OK;
                end else begin
                  res_st_q <= ST_REFUSED;
                end
              end
              CMD_EVAL: begin
                t_q      <= (in_time > T_ONE) ? T_ONE : in_time;
                prev_t_q <= key_q[0].t;
                i_q      <= IDX_W'(1);
                res_st_q <= ST_OK;
                state_q  <= S_SCAN;
              end
              default: begin
                res_st_q <= ST_OK;
                state_q  <= S_DONE;
              end
            endcase
          end
        end
        S_INS: begin
          if (ins_more) begin
            i_q <= i_q + IDX_W'(1);
          end else begin
            // open a gap at the insert position and drop the new key in
            for (int j = 1; j < MAX_KEYS; j++) begin
              if ((j > int'(i_q)) && (j <= int'(cnt_q))) begin
                key_q[j] <= key_q[j-1];
              end
            end
            key_q[i_q] <= new_q;
            cnt_q      <= cnt_q + CNT_W'(1);
            state_q    <= S_DONE;
          end
        end
        S_SCAN: begin
          if (scan_hit || scan_last) begin
            k1_q    <= rd_key;
            i_q     <= i_q - IDX_W'(1);
            state_q <= S_LD0;
          end else begin
            prev_t_q <= rd_key.t;
            i_q      <= i_q + IDX_W'(1);
          end
        end
        S_LD0: begin
          k0_q    <= rd_key;
          state_q <= S_PREP;
        end
        S_PREP: begin
          if (is_short) begin
            res_val_q <= k0_q.v;
            state_q   <= S_DONE;
          end else begin
            neg_q     <= d_s[18];
            dvd_q     <= {d_mag, 16'd0};
            rem_q     <= '0;
            len_q     <= k1_q.t - k0_q.t;
            div_cnt_q <= '0;
            state_q   <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q     <= q_bit ? TIME_W'(r_try - {1'b0, len_q}) : r_try[TIME_W-1:0];
          dvd_q     <= {dvd_q[31:0], q_bit};
          div_cnt_q <= div_cnt_q + 6'd1;
          if (div_cnt_q == 6'd32) begin
            state_q <= S_SAT;
          end
        end
        S_SAT: begin
          u_q     <= u_sat;
          m_q     <= 19'sd65536 - 19'(u_sat);
          step_q  <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          step_q <= step_q + 4'd1;
          acc_q  <= sum;
          case (step_q)
            4'd0: u2_q <= prod[35:0];
            4'd1: m2_q <= prod[36:0];
            4'd3: w3_q <= sum[55:32];
            4'd5: w0_q <= sum[55:32];
            4'd7: w1_q <= sum[55:32];
            4'd9: w2_q <= sum[55:32];
            4'd13: begin
              res_val_q <= r_sat;
              state_q   <= S_DONE;
            end
            default: ;
          endcase
        end
        S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            m_val_q <= res_val_q;
            m_st_q  <= res_st_q;
            m_cnt_q <= 5'(cnt_q);
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {3'd0, m_cnt_q, m_val_q};
  assign m_axis_tuser  = m_st_q;

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q >= CNT_W'(2)) && (cnt_q <= CNT_W'(MAX_KEYS)))
    else $error("key count out of range");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_DONE)
    else $error("output word raised outside the final state");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < len_q))
    else $error("divider remainder not below divisor");
`endif

endmodule
